// ----- rtl/spiral_matrix_fill_core_macros.svh -----
// assertion macros shared by the spiral matrix fill rtl
// no dependencies; included by the modules that check their own logic
`ifndef SPIRAL_MATRIX_FILL_CORE_MACROS_SVH
`define SPIRAL_MATRIX_FILL_CORE_MACROS_SVH

// same-cycle implication
`define SMF_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMF_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smf_pkg.sv -----
// shared types and constants for the spiral matrix fill block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

  localparam int RC_W    = 3;
  localparam int DIM_W   = 4;
  localparam int COUNT_W = 7;
  localparam int IN_W    = 15;
  localparam int OUT_W   = 16;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  localparam logic [OUT_W-1:0] EMPTY_CELL = '1;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef struct packed {
    logic            en;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } fill_wr_t;

endpackage

`default_nettype wire

// ----- rtl/smf_store.sv -----
// cell memory with per-cell filled flags, one write and one registered read port
// depends on smf_pkg
`timescale 1ns / 1ps
`default_nettype none

module smf_store import smf_pkg::*; #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_COLS   = 8,
  parameter int VALUE_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  clear,
  input  wire fill_wr_t              wr,
  input  wire logic [VALUE_BITS-1:0] wr_data,
  input  wire logic                  rd_en,
  input  wire logic [RC_W-1:0]       rd_row,
  input  wire logic [RC_W-1:0]       rd_col,
  output logic      [VALUE_BITS-1:0] rd_data,
  output logic                       rd_filled
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      filled;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;

  assign wr_addr = AW'(int'(wr.row) * MAX_COLS + int'(wr.col));
  assign rd_addr = AW'(int'(rd_row) * MAX_COLS + int'(rd_col));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      filled <= '0;
    end else if (wr.en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_filled <= filled[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smf_walker.sv -----
// spiral position tracker: shrinking bounds, heading, placed count, overflow flag
// depends on smf_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "spiral_matrix_fill_core_macros.svh"

module smf_walker import smf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic             place,
  input  wire logic [DIM_W-1:0] rows,
  input  wire logic [DIM_W-1:0] cols,
  output fill_wr_t              wr,
  output logic                  overflow
);

  logic [RC_W-1:0]    cur_row, cur_row_next;
  logic [RC_W-1:0]    cur_col, cur_col_next;
  dir_t               heading, heading_next;
  logic [RC_W-1:0]    top_in, top_in_next;
  logic [RC_W-1:0]    bot_in, bot_in_next;
  logic [RC_W-1:0]    lef_in, lef_in_next;
  logic [RC_W-1:0]    rig_in, rig_in_next;
  logic [COUNT_W-1:0] placed;
  logic               ovf;

  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] placed_inc;
  logic               full;
  logic [RC_W-1:0]    bot_lim;
  logic [RC_W-1:0]    rig_lim;

  assign total      = COUNT_W'(rows) * COUNT_W'(cols);
  assign full       = placed >= total;
  assign placed_inc = placed + COUNT_W'(1);
  assign bot_lim    = RC_W'(rows - DIM_W'(1)) - bot_in;
  assign rig_lim    = RC_W'(cols - DIM_W'(1)) - rig_in;

  assign wr.en    = place && !full;
  assign wr.row   = cur_row;
  assign wr.col   = cur_col;
  assign overflow = ovf || (place && full);

  // one step along the spiral, turning at the current bound
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    heading_next = heading;
    top_in_next  = top_in;
    bot_in_next  = bot_in;
    lef_in_next  = lef_in;
    rig_in_next  = rig_in;
    unique case (heading)
      DIR_RIGHT: begin
        if (cur_col < rig_lim) begin
          cur_col_next = cur_col + RC_W'(1);
        end else begin
          top_in_next  = top_in + RC_W'(1);
          heading_next = DIR_DOWN;
          cur_row_next = cur_row + RC_W'(1);
        end
      end
      DIR_DOWN: begin
        if (cur_row < bot_lim) begin
          cur_row_next = cur_row + RC_W'(1);
        end else begin
          rig_in_next  = rig_in + RC_W'(1);
          heading_next = DIR_LEFT;
          cur_col_next = cur_col - RC_W'(1);
        end
      end
      DIR_LEFT: begin
        if (cur_col > lef_in) begin
          cur_col_next = cur_col - RC_W'(1);
        end else begin
          bot_in_next  = bot_in + RC_W'(1);
          heading_next = DIR_UP;
          cur_row_next = cur_row - RC_W'(1);
        end
      end
      DIR_UP: begin
        if (cur_row > top_in) begin
          cur_row_next = cur_row - RC_W'(1);
        end else begin
          lef_in_next  = lef_in + RC_W'(1);
          heading_next = DIR_RIGHT;
          cur_col_next = cur_col + RC_W'(1);
        end
      end
      default: begin
        heading_next = DIR_RIGHT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cur_row <= '0;
      cur_col <= '0;
      heading <= DIR_RIGHT;
      top_in  <= '0;
      bot_in  <= '0;
      lef_in  <= '0;
      rig_in  <= '0;
      placed  <= '0;
      ovf     <= 1'b0;
    end else if (place) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        placed <= placed_inc;
        if (placed_inc < total) begin
          cur_row <= cur_row_next;
          cur_col <= cur_col_next;
          heading <= heading_next;
          top_in  <= top_in_next;
          bot_in  <= bot_in_next;
          lef_in  <= lef_in_next;
          rig_in  <= rig_in_next;
        end
      end
    end
  end

  `SMF_ASSERT_IMP(a_wr_inside, clk, rst, wr.en, ({1'b0, wr.row} < rows) && ({1'b0, wr.col} < cols), "write outside matrix")
  `SMF_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, placed <= total, "placed count above cell total")
  `SMF_ASSERT_NXT(a_restart_clear, clk, rst, restart, (placed == '0) && !ovf, "restart left fill state")

endmodule

`default_nettype wire

// ----- rtl/smf_drain.sv -----
// row-major readout sequencer: read issue, registered memory read, output and skid registers
// depends on smf_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "spiral_matrix_fill_core_macros.svh"

module smf_drain import smf_pkg::*; #(
  parameter int VALUE_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  dropped_in,
  input  wire logic [DIM_W-1:0]      rows,
  input  wire logic [DIM_W-1:0]      cols,
  output logic                       busy,
  output logic                       done,
  output logic                       rd_en,
  output logic      [RC_W-1:0]       rd_row,
  output logic      [RC_W-1:0]       rd_col,
  input  wire logic [VALUE_BITS-1:0] rd_data,
  input  wire logic                  rd_filled,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [RC_W-1:0]       row,
  output logic      [RC_W-1:0]       col,
  output logic signed [OUT_W-1:0]    cell_value,
  output logic                       dropped,
  output logic                       final_cell
);

  logic                  issuing;
  logic [RC_W-1:0]       dr;
  logic [RC_W-1:0]       dc;
  logic                  pend;
  logic [RC_W-1:0]       p_row;
  logic [RC_W-1:0]       p_col;
  logic                  p_final;
  logic                  skid_valid;
  logic [RC_W-1:0]       s_row;
  logic [RC_W-1:0]       s_col;
  logic [OUT_W-1:0]      s_val;
  logic                  s_final;

  logic                  consume;
  logic                  occ2;
  logic                  last_col;
  logic                  last_cell;
  logic                  out_free;
  logic [OUT_W-1:0]      land_val;

  assign consume   = out_valid && !out_stall;
  assign occ2      = (out_valid && skid_valid) || (pend && (out_valid || skid_valid));
  assign rd_en     = issuing && (!occ2 || consume);
  assign rd_row    = dr;
  assign rd_col    = dc;
  assign last_col  = dc == RC_W'(cols - DIM_W'(1));
  assign last_cell = last_col && (dr == RC_W'(rows - DIM_W'(1)));
  assign out_free  = !out_valid || consume;
  assign land_val  = rd_filled ? OUT_W'(rd_data) : EMPTY_CELL;
  assign done      = consume && final_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else begin
      pend <= rd_en;
      if (start) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (rd_en && last_cell) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dr      <= '0;
      dc      <= '0;
      dropped <= dropped_in;
    end else if (rd_en) begin
      if (last_col) begin
        dc <= '0;
        dr <= dr + RC_W'(1);
      end else begin
        dc <= dc + RC_W'(1);
      end
    end
    if (rd_en) begin
      p_row   <= dr;
      p_col   <= dc;
      p_final <= last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          row        <= s_row;
          col        <= s_col;
          cell_value <= s_val;
          final_cell <= s_final;
          skid_valid <= pend;
          s_row      <= p_row;
          s_col      <= p_col;
          s_val      <= land_val;
          s_final    <= p_final;
        end else if (pend) begin
          out_valid  <= 1'b1;
          row        <= p_row;
          col        <= p_col;
          cell_value <= land_val;
          final_cell <= p_final;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (pend) begin
        skid_valid <= 1'b1;
        s_row      <= p_row;
        s_col      <= p_col;
        s_val      <= land_val;
        s_final    <= p_final;
      end
    end
  end

  `SMF_ASSERT_IMP(a_no_overfill, clk, rst, 1'b1, !(pend && out_valid && skid_valid), "readout holds more than two cells")
  `SMF_ASSERT_IMP(a_out_in_busy, clk, rst, out_valid || skid_valid || pend, busy, "readout data outside a drain")
  `SMF_ASSERT_IMP(a_idle_end, clk, rst, $fell(busy), $past(done), "drain ended before the final cell")

endmodule

`default_nettype wire

// ----- rtl/spiral_matrix_fill_core.sv -----
// top level of the spiral matrix fill block: registers, fill walker, cell store, readout
// depends on smf_pkg, smf_store, smf_walker, smf_drain and the assertion macro header
//
//   port group   dir  handshake          payload
//   input        in   in_valid/in_stall  value, is_last
//   result       out  out_valid/out_stall row, col, cell_value, dropped, final_cell
//   config       in   cfg_we             cfg_index, cfg_data
//
// a value without is_last writes one cell and steps the spiral, or flags overflow if full
// a value with is_last starts a row-major readout of rows*cols cells, one per cycle
// while out_stall is low, through issue, memory and output registers; in_stall stays
// high until the final cell is taken, and the fill flags clear on that same edge
// reset is synchronous; fill flags clear at once, cell memory is never cleared
// out_stall holds the output and skid registers and throttles memory reads
`timescale 1ns / 1ps
`default_nettype none

`include "spiral_matrix_fill_core_macros.svh"

module spiral_matrix_fill_core import smf_pkg::*; #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_COLS   = 8,
  parameter int VALUE_BITS = 15
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [DIM_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [IN_W-1:0]     value,
  input  wire logic                is_last,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [RC_W-1:0]     row,
  output logic      [RC_W-1:0]     col,
  output logic signed [OUT_W-1:0]  cell_value,
  output logic                     dropped,
  output logic                     final_cell
);

  logic [DIM_W-1:0]      num_rows;
  logic [DIM_W-1:0]      num_cols;
  logic [DIM_W-1:0]      rows;
  logic [DIM_W-1:0]      cols;
  logic                  in_accept;
  logic                  busy;
  logic                  done;
  logic                  restart;
  logic                  overflow;
  fill_wr_t              wr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [RC_W-1:0]       rd_row;
  logic [RC_W-1:0]       rd_col;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  rd_filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_W'(8);
      num_cols <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_data;
        CFG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    priority if (num_rows == '0) begin
      rows = DIM_W'(1);
    end else if (int'(num_rows) > MAX_ROWS) begin
      rows = DIM_W'(MAX_ROWS);
    end else begin
      rows = num_rows;
    end
    priority if (num_cols == '0) begin
      cols = DIM_W'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      cols = DIM_W'(MAX_COLS);
    end else begin
      cols = num_cols;
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign restart   = cfg_we || done;
  assign wr_data   = VALUE_BITS'(value);

  smf_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .place    (in_accept),
    .rows     (rows),
    .cols     (cols),
    .wr       (wr),
    .overflow (overflow)
  );

  smf_store #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .clear     (restart),
    .wr        (wr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .rd_data   (rd_data),
    .rd_filled (rd_filled)
  );

  smf_drain #(
    .VALUE_BITS (VALUE_BITS)
  ) u_drain (
    .clk        (clk),
    .rst        (rst),
    .start      (in_accept && is_last),
    .dropped_in (overflow),
    .rows       (rows),
    .cols       (cols),
    .busy       (busy),
    .done       (done),
    .rd_en      (rd_en),
    .rd_row     (rd_row),
    .rd_col     (rd_col),
    .rd_data    (rd_data),
    .rd_filled  (rd_filled),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .dropped    (dropped),
    .final_cell (final_cell)
  );

  `SMF_ASSERT_IMP(a_no_write_in_drain, clk, rst, busy, !wr.en, "cell write during readout")
  `SMF_ASSERT_IMP(a_no_read_while_fill, clk, rst, rd_en, busy && !wr.en, "read outside a readout")
  `SMF_ASSERT_NXT(a_final_frees_input, clk, rst, out_valid && !out_stall && final_cell, !in_stall, "input still stalled after final cell")

endmodule

`default_nettype wire
